>>> rtl/crp_pkg.sv
`default_nettype none

package crp_pkg;

  // Field widths of the command and result ports.
  localparam int ACTION_W = 3;
  localparam int FRAME_W  = 6;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;

  // Defaults for the top-level parameters.
  localparam int FRAMES_DEF   = 64;
  localparam int PIN_BITS_DEF = 8;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_RESERVE = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_TOUCH   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PIN     = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_UNPIN   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FREE    = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic lookup;
    logic sweep;
    logic exec;
  } crp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic is_reserve;
    logic sweep_end;
  } crp_sts_t;

endpackage

`default_nettype wire

>>> rtl/crp_ctrl.sv
`default_nettype none

module crp_ctrl
  import crp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire crp_sts_t sts_i,
  output crp_cmd_t      cmd_o,
  output logic          busy
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.lookup = 1'b1;
        state_d      = sts_i.is_reserve ? S_SWEEP : S_EXEC;
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_end) begin
          state_d = S_IDLE;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // A sweep or an execute step is only ever entered through a lookup.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP || state_q == S_EXEC) && $past(state_q) != S_SWEEP
      |-> $past(state_q) == S_LOOK)
    else $error("sweep or execute entered without a lookup");

endmodule

`default_nettype wire

>>> rtl/crp_dp.sv
`default_nettype none

module crp_dp
  import crp_pkg::*;
#(
  parameter int FRAMES   = FRAMES_DEF,
  parameter int PIN_BITS = PIN_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [ACTION_W-1:0] action_i,
  input  wire logic [FRAME_W-1:0]  frame_i,
  input  wire crp_cmd_t            cmd_i,
  output crp_sts_t                 sts_o,
  output logic                     done_o,
  output logic [SLOT_W-1:0]        slot_o,
  output logic                     must_flush_o,
  output logic [STATUS_W-1:0]      status_o
);

  localparam int HAND_W = $clog2(FRAMES);
  localparam int STEP_W = $clog2(2 * FRAMES);
  localparam int ENT_W  = PIN_BITS + 2;
  localparam logic [HAND_W-1:0]   LAST_FRAME = HAND_W'(FRAMES - 1);
  localparam logic [STEP_W-1:0]   LAST_STEP  = STEP_W'(2 * FRAMES - 1);
  localparam logic [PIN_BITS-1:0] PIN_MAX    = '1;

  // Each entry holds {present, accessed, pin count}.
  logic [ENT_W-1:0] mem [FRAMES];

  logic [ACTION_W-1:0] action_q;
  logic [FRAME_W-1:0]  frame_q;
  logic [HAND_W-1:0]   hand_q, hand_d, hand_nxt;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [HAND_W-1:0]   clr_q, clr_d;
  logic [ENT_W-1:0]    rd_q;
  logic [HAND_W-1:0]   rd_addr;

  logic                we;
  logic [HAND_W-1:0]   waddr;
  logic [ENT_W-1:0]    wdata;

  logic                valid_q, valid_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic                flush_q, flush_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic [31:0]         frame_ext, hand_ext;
  logic [HAND_W-1:0]   frame_addr;
  logic                frame_ok;
  logic [SLOT_W-1:0]   hand_slot;
  logic                ent_present, ent_access;
  logic [PIN_BITS-1:0] ent_pin;
  logic                is_reserve;
  logic                skip;
  logic                sweep_end;

  assign frame_ext  = 32'(frame_q);
  assign frame_addr = frame_ext[HAND_W-1:0];
  assign frame_ok   = frame_ext < 32'(FRAMES);
  assign hand_ext   = 32'(hand_q);
  assign hand_slot  = hand_ext[SLOT_W-1:0];
  assign hand_nxt   = (hand_q == LAST_FRAME) ? '0 : hand_q + HAND_W'(1);

  assign ent_present = rd_q[ENT_W-1];
  assign ent_access  = rd_q[ENT_W-2];
  assign ent_pin     = rd_q[PIN_BITS-1:0];

  assign is_reserve = (action_q == ACT_RESERVE);

  // During a sweep the next frame is read ahead; it is simply dropped when the sweep stops.
  assign rd_addr = cmd_i.lookup ? (is_reserve ? hand_q : frame_addr) : hand_nxt;

  always_comb begin
    we        = 1'b0;
    waddr     = hand_q;
    wdata     = '0;
    hand_d    = hand_q;
    step_d    = step_q;
    clr_d     = clr_q;
    valid_d   = 1'b0;
    slot_d    = '0;
    flush_d   = 1'b0;
    status_d  = ST_OK;
    skip      = 1'b0;
    sweep_end = 1'b0;

    if (cmd_i.clear) begin
      we    = 1'b1;
      waddr = clr_q;
      clr_d = clr_q + HAND_W'(1);
    end

    if (cmd_i.lookup) begin
      step_d = '0;
    end

    if (cmd_i.sweep) begin
      if (!ent_present || (ent_pin == '0 && !ent_access)) begin
        we        = 1'b1;
        wdata     = {1'b1, 1'b0, {PIN_BITS{1'b0}}};
        hand_d    = hand_nxt;
        valid_d   = 1'b1;
        slot_d    = hand_slot;
        flush_d   = ent_present;
        sweep_end = 1'b1;
      end else begin
        skip   = 1'b1;
        hand_d = hand_nxt;
        if (ent_pin == '0) begin
          // Second chance: clear the access bit and move on.
          we    = 1'b1;
          wdata = {1'b1, 1'b0, ent_pin};
        end
      end
      if (skip) begin
        step_d = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          valid_d   = 1'b1;
          status_d  = ST_FULL;
          sweep_end = 1'b1;
        end
      end
    end

    if (cmd_i.exec) begin
      valid_d = 1'b1;
      waddr   = frame_addr;
      priority if (action_q > ACT_FREE || !frame_ok) begin
        status_d = ST_BAD;
      end else if (action_q == ACT_FREE) begin
        we    = 1'b1;
        wdata = '0;
      end else if (!ent_present) begin
        status_d = ST_BAD;
      end else if (action_q == ACT_TOUCH) begin
        we    = 1'b1;
        wdata = {1'b1, 1'b1, ent_pin};
      end else if (action_q == ACT_PIN) begin
        we    = 1'b1;
        wdata = {1'b1, ent_access, (ent_pin == PIN_MAX) ? ent_pin : ent_pin + PIN_BITS'(1)};
      end else if (ent_pin == '0) begin
        status_d = ST_BAD;
      end else begin
        we    = 1'b1;
        wdata = {1'b1, ent_access, ent_pin - PIN_BITS'(1)};
      end
    end
  end

  assign sts_o.clear_last = (clr_q == LAST_FRAME);
  assign sts_o.is_reserve = is_reserve;
  assign sts_o.sweep_end  = sweep_end;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      frame_q  <= frame_i;
    end
    slot_q   <= slot_d;
    flush_q  <= flush_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hand_q  <= '0;
      step_q  <= '0;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      hand_q  <= hand_d;
      step_q  <= step_d;
      clr_q   <= clr_d;
      valid_q <= valid_d;
    end
  end

  assign done_o       = valid_q;
  assign slot_o       = slot_q;
  assign must_flush_o = flush_q;
  assign status_o     = status_q;

  // The strobe never lasts more than one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("result strobe held for two cycles");

  // Actions other than reserve never move the hand.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> $stable(hand_q))
    else $error("hand moved by a non-reserve action");

endmodule

`default_nettype wire

>>> rtl/clock_replacement_policy.sv
// Channel   Ports                                    Handshake
// command   action_i, frame_i                        taken when start && !busy
// result    slot_o, must_flush_o, status_o           valid for the one cycle done_o is high
//
// After reset the frame table is cleared, one frame a cycle; busy is high throughout. Touch,
// pin, unpin and free step through a table read, an update and the result cycle, in which
// busy is already low. A reserve runs a table read and then a sweep in which the hand
// visits k frames, k from 1 to 2*FRAMES; the single table read port sets one frame per cycle.
// The result cannot be held off: it is shown for exactly one cycle.
`default_nettype none

module clock_replacement_policy
  import crp_pkg::*;
#(
  parameter int FRAMES   = FRAMES_DEF,
  parameter int PIN_BITS = PIN_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [ACTION_W-1:0] action_i,
  input  wire logic [FRAME_W-1:0]  frame_i,
  output logic                     done_o,
  output logic [SLOT_W-1:0]        slot_o,
  output logic                     must_flush_o,
  output logic [STATUS_W-1:0]      status_o
);

  crp_cmd_t cmd;
  crp_sts_t sts;

  crp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  crp_dp #(
    .FRAMES   (FRAMES),
    .PIN_BITS (PIN_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .action_i     (action_i),
    .frame_i      (frame_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .done_o       (done_o),
    .slot_o       (slot_o),
    .must_flush_o (must_flush_o),
    .status_o     (status_o)
  );

  // The block is ready again in the cycle that shows a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  // A flush is only requested for a successful reserve.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && must_flush_o |-> status_o == ST_OK)
    else $error("flush flagged on a failed item");

  // A failed item carries no slot and no flush.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> slot_o == '0 && !must_flush_o)
    else $error("failed item carries a slot or flush");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench
  import crp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int                  NFRAMES      = FRAMES_DEF;
  localparam logic [7:0]          PIN_CEILING  = '1;
  localparam logic [ACTION_W-1:0] ACT_TOP_CODE = '1;
  localparam int                  PHASE_ITEMS  = 540;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                flush;
    logic [STATUS_W-1:0] status;
  } frame_outcome_t;

  class frame_table_scoreboard;
    bit                  present[NFRAMES];
    bit                  accessed[NFRAMES];
    bit [7:0]            pins[NFRAMES];
    bit [FRAME_W-1:0]    hand;
    frame_outcome_t      outstanding[$];
    bit [SLOT_W-1:0]     last_slot;
    int                  errors;
    int                  results;
    int                  victims;
    int                  pool_full;
    int                  rejected;

    // Works out what the block must answer for one accepted item.
    function void note_command(logic [ACTION_W-1:0] act, logic [FRAME_W-1:0] frame);
      frame_outcome_t   res;
      bit               found;
      bit [FRAME_W-1:0] h;
      res = '0;
      res.status = ST_OK;
      case (act)
        ACT_RESERVE: begin
          found = 1'b0;
          for (int i = 0; i < 2 * NFRAMES; i++) begin
            h = hand;
            if (!present[h]) begin
              found = 1'b1;
              break;
            end
            if (pins[h] != 0) begin
              hand = h + 1'b1;
              continue;
            end
            if (accessed[h]) begin
              accessed[h] = 1'b0;
              hand = h + 1'b1;
              continue;
            end
            res.flush = 1'b1;
            found = 1'b1;
            break;
          end
          if (found) begin
            h = hand;
            res.slot = h;
            present[h] = 1'b1;
            accessed[h] = 1'b0;
            pins[h] = '0;
            hand = h + 1'b1;
            last_slot = h;
          end else begin
            res.status = ST_FULL;
          end
        end
        ACT_FREE: begin
          present[frame] = 1'b0;
          accessed[frame] = 1'b0;
          pins[frame] = '0;
        end
        ACT_TOUCH, ACT_PIN, ACT_UNPIN: begin
          if (!present[frame]) begin
            res.status = ST_BAD;
          end else if (act == ACT_TOUCH) begin
            accessed[frame] = 1'b1;
          end else if (act == ACT_PIN) begin
            if (pins[frame] != PIN_CEILING) pins[frame] = pins[frame] + 1'b1;
          end else if (pins[frame] == 0) begin
            res.status = ST_BAD;
          end else begin
            pins[frame] = pins[frame] - 1'b1;
          end
        end
        default: res.status = ST_BAD;
      endcase
      if (res.flush) victims++;
      if (res.status == ST_FULL) pool_full++;
      if (res.status == ST_BAD) rejected++;
      outstanding.push_back(res);
    endfunction

    function void check_result(logic [SLOT_W-1:0] slot, logic flush,
                               logic [STATUS_W-1:0] status);
      frame_outcome_t want;
      if (outstanding.size() == 0) begin
        $error("result with no item outstanding: slot %0d must_flush %0d status %0d",
               slot, flush, status);
        errors++;
        return;
      end
      want = outstanding.pop_front();
      results++;
      if (slot !== want.slot) begin
        $error("slot: expected %0d, got %0d", want.slot, slot);
        errors++;
      end
      if (flush !== want.flush) begin
        $error("must_flush: expected %0d, got %0d", want.flush, flush);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
    endfunction

    function int empty_frames();
      int n;
      n = 0;
      foreach (present[i]) if (!present[i]) n++;
      return n;
    endfunction

    // Mostly a frame that holds a page, so that touch, pin and unpin do real work.
    function bit [FRAME_W-1:0] pick_frame();
      int held[$];
      foreach (present[i]) if (present[i]) held.push_back(i);
      if (held.size() == 0 || $urandom_range(99) < 35) begin
        return FRAME_W'($urandom_range(NFRAMES - 1));
      end
      return FRAME_W'(held[$urandom_range(held.size() - 1)]);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic [ACTION_W-1:0] action_i = '0;
  logic [FRAME_W-1:0]  frame_i = '0;
  logic                busy;
  logic                done_o;
  logic [SLOT_W-1:0]   slot_o;
  logic                must_flush_o;
  logic [STATUS_W-1:0] status_o;

  frame_table_scoreboard sb = new();
  int items = 0;
  int idle_pct = 0;

  clock_replacement_policy u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .frame_i     (frame_i),
    .done_o      (done_o),
    .slot_o      (slot_o),
    .must_flush_o(must_flush_o),
    .status_o    (status_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(slot_o, must_flush_o, status_o);
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic issue(input logic [ACTION_W-1:0] act, input logic [FRAME_W-1:0] frame);
    int gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(15) == 0) ? $urandom_range(20, 140) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    action_i <= act;
    frame_i <= frame;
    do @(posedge clk_i); while (busy);
    sb.note_command(act, frame);
    items++;
    @(negedge clk_i);
  endtask

  task automatic random_command();
    int r;
    r = $urandom_range(99);
    if (r < 36)      issue(ACT_RESERVE, FRAME_W'($urandom_range(NFRAMES - 1)));
    else if (r < 54) issue(ACT_TOUCH, sb.pick_frame());
    else if (r < 69) issue(ACT_PIN, sb.pick_frame());
    else if (r < 84) issue(ACT_UNPIN, sb.pick_frame());
    else if (r < 96) issue(ACT_FREE, sb.pick_frame());
    else             issue(ACTION_W'($urandom_range(ACT_FREE + 1, ACT_TOP_CODE)),
                           FRAME_W'($urandom_range(63)));
  endtask

  // Fills the pool, pins every frame, asks twice for a frame that cannot be had, then loosens it.
  task automatic pool_full_episode();
    int guard;
    guard = 0;
    while (sb.empty_frames() != 0 && guard < 4 * NFRAMES) begin
      issue(ACT_RESERVE, FRAME_W'($urandom_range(NFRAMES - 1)));
      guard++;
    end
    for (int f = 0; f < NFRAMES; f++) begin
      if ($urandom_range(3) == 0) issue(ACT_TOUCH, FRAME_W'(f));
      issue(ACT_PIN, FRAME_W'(f));
    end
    issue(ACT_RESERVE, FRAME_W'($urandom_range(NFRAMES - 1)));
    issue(ACT_RESERVE, FRAME_W'($urandom_range(NFRAMES - 1)));
    for (int f = 0; f < NFRAMES; f++) begin
      if ($urandom_range(99) < 55) issue(ACT_UNPIN, FRAME_W'(f));
      else if ($urandom_range(99) < 25) issue(ACT_FREE, FRAME_W'(f));
    end
  endtask

  task automatic pin_saturation_episode();
    bit [FRAME_W-1:0] f;
    issue(ACT_RESERVE, FRAME_W'($urandom_range(NFRAMES - 1)));
    f = sb.last_slot;
    repeat (int'(PIN_CEILING) + 3) issue(ACT_PIN, f);
    issue(ACT_UNPIN, f);
    issue(ACT_TOUCH, f);
    issue(ACT_FREE, f);
  endtask

  initial begin
    int phase_pct[3];
    int target;
    int waited;
    phase_pct = '{0, 55, 31};
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: requests on empty frames, ignored frame field, pins, frees and bad codes.
    issue(ACT_TOUCH, 6'd0);
    issue(ACT_PIN, 6'd63);
    issue(ACT_UNPIN, 6'd5);
    issue(ACT_FREE, 6'd7);
    issue(ACT_RESERVE, 6'd0);
    issue(ACT_RESERVE, 6'd63);
    issue(ACT_UNPIN, 6'd0);
    issue(ACT_PIN, 6'd0);
    issue(ACT_PIN, 6'd0);
    issue(ACT_UNPIN, 6'd0);
    issue(ACT_TOUCH, 6'd1);
    issue(ACT_FREE + 1'b1, 6'd63);
    issue(ACT_TOP_CODE - 1'b1, 6'd0);
    issue(ACT_TOP_CODE, 6'd42);
    issue(ACT_FREE, 6'd0);
    issue(ACT_RESERVE, 6'd21);
    issue(ACT_RESERVE, 6'd42);
    issue(ACT_TOUCH, 6'd2);
    issue(ACT_FREE, 6'd63);
    issue(ACT_RESERVE, 6'd0);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = phase_pct[phase];
      target = items + PHASE_ITEMS;
      if (phase == 0) pin_saturation_episode();
      pool_full_episode();
      while (items < target) begin
        // Runs without gaps inside the idling phases as well.
        if (idle_pct != 0 && $urandom_range(9) == 0) begin
          idle_pct = 0;
          repeat ($urandom_range(10, 30)) random_command();
          idle_pct = phase_pct[phase];
        end else begin
          random_command();
        end
      end
    end
    start <= 1'b0;

    waited = 0;
    while (sb.outstanding.size() != 0 && waited < 4 * NFRAMES + 16) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (2 * NFRAMES + 4) @(posedge clk_i);
    if (sb.outstanding.size() != 0) begin
      $error("%0d expected results never arrived", sb.outstanding.size());
      sb.errors++;
    end

    $display("Issued %0d items and checked %0d results: %0d victims flushed,",
             items, sb.results, sb.victims);
    $display("%0d reserves on a fully pinned pool, %0d requests rejected.",
             sb.pool_full, sb.rejected);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
